// ===== rtl/core/pcli_pkg.sv =====
// Shared types and constants for the polyline closest lerp index unit.
`default_nettype none

package pcli_pkg;

    localparam int DEFAULT_MAX_VERTICES = 256;
    localparam int COORD_BITS           = 16;
    localparam int FRACTION_BITS        = 16;
    localparam int GUARD_BITS           = (FRACTION_BITS < (29 - COORD_BITS)) ?
                                          FRACTION_BITS : (29 - COORD_BITS);
    localparam int ROUND_SHIFT          = FRACTION_BITS - GUARD_BITS;
    localparam int INDEX_BITS           = 8;
    localparam int COUNT_BITS           = 9;
    localparam int FRAC_OUT_BITS        = FRACTION_BITS + 1;
    localparam int DIFF_BITS            = COORD_BITS + 1;
    localparam int DOT_BITS             = 2 * COORD_BITS + 3;
    localparam int REM_BITS             = 2 * COORD_BITS + 2;
    localparam int OFFMAG_BITS          = COORD_BITS + FRAC_OUT_BITS;
    localparam int RES_BITS             = 32;
    localparam int DIST_BITS            = 2 * RES_BITS;
    localparam int DIV_CNT_BITS         = $clog2(FRACTION_BITS);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_CLOSED_PATH  = 1'b0;
    localparam logic REG_VERTEX_COUNT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_CUR,
        ST_RD_NXT,
        ST_DIFF,
        ST_MUL,
        ST_SUM,
        ST_CHK,
        ST_DIV,
        ST_OFF,
        ST_RES,
        ST_SQ,
        ST_CMP,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/polyline_closest_lerp_index_unit.sv =====
// Closest segment and Q1.16 fraction on a stored 2-D polyline.
`default_nettype none

// Vertex writes (tuser 0) store a point. A query (tuser 1) walks the segments one
// at a time through the vertex memory: each segment passes through the read,
// difference, multiply, sum, check, offset, residual, square and compare states,
// and through the bit-serial divider as well when its projection falls strictly
// inside the segment. A query on fewer than two vertices goes straight to the output.
// The next item is taken once the result sits in the output register.
module polyline_closest_lerp_index_unit #(
    parameter int MAX_VERTICES = pcli_pkg::DEFAULT_MAX_VERTICES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // vertex_index[7:0], x_coord, y_coord
    input  wire logic        s_axis_tuser,   // operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // segment_index[7:0], fraction[16:0], zeros
    output logic             m_axis_tuser,   // too_few_vertices
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_data
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int CB = pcli_pkg::COORD_BITS;
    localparam int SH = pcli_pkg::ROUND_SHIFT;
    localparam int GB = pcli_pkg::GUARD_BITS;
    localparam int FB = pcli_pkg::FRACTION_BITS;
    localparam int FW = pcli_pkg::FRAC_OUT_BITS;
    localparam int DF = pcli_pkg::DIFF_BITS;
    localparam int DT = pcli_pkg::DOT_BITS;
    localparam int RM = pcli_pkg::REM_BITS;
    localparam int OM = pcli_pkg::OFFMAG_BITS;
    localparam int RB = pcli_pkg::RES_BITS;
    localparam int DB = pcli_pkg::DIST_BITS;
    localparam int KB = pcli_pkg::DIV_CNT_BITS;
    localparam logic [OM:0] HALF = (SH > 0) ? (OM+1)'(1) << (SH - 1) : '0;

    pcli_pkg::state_t state_reg, state_next;

    logic [2*CB-1:0] mem [MAX_VERTICES];
    logic [2*CB-1:0] rd_data_reg;
    logic [AW-1:0]   rd_addr;
    logic            mem_we;
    logic [AW-1:0]   wr_addr;

    logic            closed_reg;
    logic [8:0]      count_reg;

    logic [NW-1:0]   n_reg, n_next, n_sat;
    logic [AW-1:0]   i_reg, i_next, j_idx;
    logic            last_seg;

    logic signed [CB-1:0] tx_reg, tx_next, ty_reg, ty_next;
    logic signed [CB-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [DF-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [DF-1:0] ux_reg, ux_next, uy_reg, uy_next;
    logic signed [2*DF-1:0] pxx_reg, pxx_next, pyy_reg, pyy_next;
    logic signed [2*DF-1:0] pdx_reg, pdx_next, pdy_reg, pdy_next;
    logic signed [DT-1:0] dot_reg, dot_next;
    logic [RM-1:0]        len_reg, len_next, rem_reg, rem_next, rem2;
    logic [FW-1:0]        f_reg, f_next;
    logic [KB-1:0]        k_reg, k_next;
    logic [OM-1:0]        mx_reg, mx_next, my_reg, my_next;
    logic [RB-1:0]        ax_reg, ax_next, ay_reg, ay_next;
    logic [DB-1:0]        sx_reg, sx_next, sy_reg, sy_next;
    logic [DB-1:0]        best_d_reg, best_d_next, seg_dist;
    logic [AW-1:0]        best_i_reg, best_i_next;
    logic [FW-1:0]        best_f_reg, best_f_next;
    logic                 few_reg, few_next;

    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_index_reg, out_index_next;
    logic [FW-1:0]        out_frac_reg, out_frac_next;
    logic                 out_few_reg, out_few_next;

    logic signed [DF-1:0] adx, ady;
    logic [OM:0]          rx_mag, ry_mag;
    logic signed [RB-1:0] offx, offy, rx, ry, tsx, tsy;
    logic signed [CB-1:0] in_x, in_y;
    logic                 accept;

    assign in_x   = s_axis_tdata[8 +: CB];
    assign in_y   = s_axis_tdata[24 +: CB];
    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == pcli_pkg::ST_IDLE);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_few_reg;
    assign m_axis_tdata  = {7'd0, out_frac_reg, out_index_reg};

    assign n_sat = (32'(count_reg) > 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(count_reg);
    assign j_idx = ((NW'(i_reg) + NW'(1)) == n_reg) ? '0 : AW'(NW'(i_reg) + NW'(1));
    assign last_seg = closed_reg ? ((NW'(i_reg) + NW'(1)) == n_reg)
                                 : ((NW'(i_reg) + NW'(2)) == n_reg);
    assign wr_addr = AW'(s_axis_tdata[7:0]);
    assign mem_we  = accept && (s_axis_tuser == pcli_pkg::OP_WRITE)
                     && (32'(s_axis_tdata[7:0]) < 32'(MAX_VERTICES));
    assign rem2 = {rem_reg[RM-2:0], 1'b0};
    assign seg_dist = sx_reg + sy_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= {in_y, in_x};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_reg <= 1'b0;
            count_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pcli_pkg::REG_CLOSED_PATH:  closed_reg <= cfg_data[0];
                pcli_pkg::REG_VERTEX_COUNT: count_reg  <= cfg_data;
                default:                    count_reg  <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcli_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;   tx_reg <= tx_next;   ty_reg <= ty_next;
        cx_reg <= cx_next; cy_reg <= cy_next;   dx_reg <= dx_next;
        dy_reg <= dy_next; ux_reg <= ux_next;   uy_reg <= uy_next;
        pxx_reg <= pxx_next; pyy_reg <= pyy_next;
        pdx_reg <= pdx_next; pdy_reg <= pdy_next;
        dot_reg <= dot_next; len_reg <= len_next; rem_reg <= rem_next;
        f_reg <= f_next;   mx_reg <= mx_next;   my_reg <= my_next;
        ax_reg <= ax_next; ay_reg <= ay_next;   sx_reg <= sx_next;
        sy_reg <= sy_next; best_d_reg <= best_d_next;
        best_i_reg <= best_i_next; best_f_reg <= best_f_next;
        few_reg <= few_next;
        out_index_reg <= out_index_next;
        out_frac_reg  <= out_frac_next;
        out_few_reg   <= out_few_next;
    end

    always_comb
    begin
        adx    = dx_reg[DF-1] ? -dx_reg : dx_reg;
        ady    = dy_reg[DF-1] ? -dy_reg : dy_reg;
        rx_mag = ((OM+1)'(mx_reg) + HALF) >> SH;
        ry_mag = ((OM+1)'(my_reg) + HALF) >> SH;
        offx   = dx_reg[DF-1] ? -RB'(rx_mag) : RB'(rx_mag);
        offy   = dy_reg[DF-1] ? -RB'(ry_mag) : RB'(ry_mag);
        tsx    = RB'(ux_reg) <<< GB;
        tsy    = RB'(uy_reg) <<< GB;
        rx     = tsx - offx;
        ry     = tsy - offy;

        state_next = state_reg;
        rd_addr = i_reg;
        n_next = n_reg;   i_next = i_reg;   k_next = k_reg;
        tx_next = tx_reg; ty_next = ty_reg; cx_next = cx_reg; cy_next = cy_reg;
        dx_next = dx_reg; dy_next = dy_reg; ux_next = ux_reg; uy_next = uy_reg;
        pxx_next = pxx_reg; pyy_next = pyy_reg; pdx_next = pdx_reg; pdy_next = pdy_reg;
        dot_next = dot_reg; len_next = len_reg; rem_next = rem_reg; f_next = f_reg;
        mx_next = mx_reg; my_next = my_reg; ax_next = ax_reg; ay_next = ay_reg;
        sx_next = sx_reg; sy_next = sy_reg;
        best_d_next = best_d_reg; best_i_next = best_i_reg; best_f_next = best_f_reg;
        few_next = few_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_index_next = out_index_reg;
        out_frac_next  = out_frac_reg;
        out_few_next   = out_few_reg;

        unique case (state_reg)
            pcli_pkg::ST_IDLE:
            begin
                if (accept && (s_axis_tuser == pcli_pkg::OP_QUERY))
                begin
                    n_next  = n_sat;
                    tx_next = in_x;
                    ty_next = in_y;
                    i_next  = '0;
                    best_i_next = '0;
                    best_f_next = '0;
                    few_next = (n_sat < NW'(2));
                    state_next = (n_sat < NW'(2)) ? pcli_pkg::ST_OUT : pcli_pkg::ST_RD_CUR;
                end
            end
            pcli_pkg::ST_RD_CUR:
            begin
                rd_addr = i_reg;
                state_next = pcli_pkg::ST_RD_NXT;
            end
            pcli_pkg::ST_RD_NXT:
            begin
                rd_addr = j_idx;
                cx_next = rd_data_reg[CB-1:0];
                cy_next = rd_data_reg[2*CB-1:CB];
                state_next = pcli_pkg::ST_DIFF;
            end
            pcli_pkg::ST_DIFF:
            begin
                dx_next = DF'($signed(rd_data_reg[CB-1:0])) - DF'(cx_reg);
                dy_next = DF'($signed(rd_data_reg[2*CB-1:CB])) - DF'(cy_reg);
                ux_next = DF'(tx_reg) - DF'(cx_reg);
                uy_next = DF'(ty_reg) - DF'(cy_reg);
                state_next = pcli_pkg::ST_MUL;
            end
            pcli_pkg::ST_MUL:
            begin
                pxx_next = dx_reg * dx_reg;
                pyy_next = dy_reg * dy_reg;
                pdx_next = ux_reg * dx_reg;
                pdy_next = uy_reg * dy_reg;
                state_next = pcli_pkg::ST_SUM;
            end
            pcli_pkg::ST_SUM:
            begin
                dot_next = DT'(pdx_reg) + DT'(pdy_reg);
                len_next = RM'(pxx_reg) + RM'(pyy_reg);
                state_next = pcli_pkg::ST_CHK;
            end
            pcli_pkg::ST_CHK:
            begin
                f_next   = '0;
                k_next   = '0;
                rem_next = dot_reg[RM-1:0];
                state_next = pcli_pkg::ST_OFF;
                if ((len_reg != '0) && (dot_reg > 0))
                begin
                    if (dot_reg[RM-1:0] >= len_reg)
                    begin
                        f_next = FW'(1) << FB;
                    end
                    else
                    begin
                        state_next = pcli_pkg::ST_DIV;
                    end
                end
            end
            pcli_pkg::ST_DIV:
            begin
                if (rem2 >= len_reg)
                begin
                    rem_next = rem2 - len_reg;
                    f_next   = {f_reg[FW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2;
                    f_next   = {f_reg[FW-2:0], 1'b0};
                end
                k_next = k_reg + KB'(1);
                if (k_reg == KB'(FB - 1))
                begin
                    state_next = pcli_pkg::ST_OFF;
                end
            end
            pcli_pkg::ST_OFF:
            begin
                mx_next = OM'(adx[CB-1:0]) * OM'(f_reg);
                my_next = OM'(ady[CB-1:0]) * OM'(f_reg);
                state_next = pcli_pkg::ST_RES;
            end
            pcli_pkg::ST_RES:
            begin
                ax_next = rx[RB-1] ? RB'(-rx) : RB'(rx);
                ay_next = ry[RB-1] ? RB'(-ry) : RB'(ry);
                state_next = pcli_pkg::ST_SQ;
            end
            pcli_pkg::ST_SQ:
            begin
                sx_next = DB'(ax_reg) * DB'(ax_reg);
                sy_next = DB'(ay_reg) * DB'(ay_reg);
                state_next = pcli_pkg::ST_CMP;
            end
            pcli_pkg::ST_CMP:
            begin
                if ((i_reg == '0) || (seg_dist < best_d_reg))
                begin
                    best_d_next = seg_dist;
                    best_i_next = i_reg;
                    best_f_next = f_reg;
                end
                if (last_seg)
                begin
                    state_next = pcli_pkg::ST_OUT;
                end
                else
                begin
                    i_next = i_reg + AW'(1);
                    state_next = pcli_pkg::ST_RD_CUR;
                end
            end
            pcli_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = 8'(best_i_reg);
                    out_frac_next  = best_f_reg;
                    out_few_next   = few_reg;
                    state_next     = pcli_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pcli_pkg::ST_IDLE;
            end
        endcase
    end

    a_few_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[24:0] == 25'd0))
        else $error("too_few result carries nonzero payload");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_frac_reg <= (FW'(1) << FB)))
        else $error("fraction above one");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_axis_tuser == pcli_pkg::OP_QUERY)) |=> !s_axis_tready)
        else $error("query accepted without leaving idle");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pcli_pkg::ST_DIV) |-> (rem_reg < len_reg))
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// ===== tb/polyline_closest_lerp_index_unit_test.sv =====
// Testbench for the polyline closest lerp index unit: predicted nearest segment and fraction.
`timescale 1ns / 100ps

module polyline_closest_lerp_index_unit_test;

    localparam int  LIMIT_CYCLES = 4000000;
    localparam int  HOLD_CYCLES  = 3000;
    localparam int  ITEM_GOAL    = 1050;

    typedef struct packed {
        logic [7:0]  seg;
        logic [16:0] frac;
        logic        few;
    } nearest_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_we;
    logic        cfg_index;
    logic [8:0]  cfg_data;

    nearest_t    nearest_q[$];
    shortint     pt_x[256];
    shortint     pt_y[256];
    logic        closed_mode;
    logic [8:0]  point_count;
    int          errors, items_sent, queries_sent, results_seen, phases, cycles;
    bit          steady;
    int          hold_reqs, hold_seen, hold_left;

    polyline_closest_lerp_index_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint offset_of(longint d, longint f);
        longint mag, r;
        mag = (d < 0 ? -d : d) * f;
        r = (pcli_pkg::ROUND_SHIFT > 0) ?
            ((mag + (64'sd1 << (pcli_pkg::ROUND_SHIFT - 1))) >>> pcli_pkg::ROUND_SHIFT) : mag;
        return d < 0 ? -r : r;
    endfunction

    function automatic nearest_t nearest_on_path(longint gx, longint gy);
        nearest_t res;
        longint n, segs, j, dx, dy, tx, ty, dot, len2, f, rx, ry;
        longint unsigned ax, ay, seg_dist, best;
        res = '0;
        best = 0;
        n = (point_count > 256) ? 256 : point_count;
        if (n < 2)
        begin
            res.few = 1'b1;
            return res;
        end
        segs = closed_mode ? n : n - 1;
        for (longint i = 0; i < segs; i++)
        begin
            j = (i + 1 == n) ? 0 : i + 1;
            dx = longint'(pt_x[j]) - pt_x[i];
            dy = longint'(pt_y[j]) - pt_y[i];
            tx = gx - pt_x[i];
            ty = gy - pt_y[i];
            dot = tx * dx + ty * dy;
            len2 = dx * dx + dy * dy;
            f = 0;
            if (len2 != 0)
            begin
                if (dot <= 0)
                    f = 0;
                else if (dot >= len2)
                    f = 64'sd1 << pcli_pkg::FRACTION_BITS;
                else
                    f = (dot <<< pcli_pkg::FRACTION_BITS) / len2;
            end
            rx = tx * (64'sd1 << pcli_pkg::GUARD_BITS) - offset_of(dx, f);
            ry = ty * (64'sd1 << pcli_pkg::GUARD_BITS) - offset_of(dy, f);
            ax = rx < 0 ? -rx : rx;
            ay = ry < 0 ? -ry : ry;
            seg_dist = ax * ax + ay * ay;
            if (i == 0 || seg_dist < best)
            begin
                best = seg_dist;
                res.seg = i[7:0];
                res.frac = f[16:0];
            end
        end
        return res;
    endfunction

    task automatic send_item(logic op, logic [7:0] idx, shortint x, shortint y);
        if (!steady && $urandom_range(99) < 21)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {y, x, idx};
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
        if (op == pcli_pkg::OP_WRITE)
        begin
            pt_x[idx] = x;
            pt_y[idx] = y;
        end
        else
        begin
            queries_sent++;
            nearest_q.push_back(nearest_on_path(x, y));
        end
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (nearest_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [8:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == pcli_pkg::REG_CLOSED_PATH)
            closed_mode = value[0];
        else
            point_count = value;
    endtask

    task automatic set_path(logic closed, logic [8:0] count);
        drain();
        write_reg(pcli_pkg::REG_CLOSED_PATH, {8'd0, closed});
        write_reg(pcli_pkg::REG_VERTEX_COUNT, count);
        cfg_we <= 1'b0;
        phases++;
    endtask

    task automatic test_too_few;
        set_path(1'b0, 9'd0);
        send_item(pcli_pkg::OP_QUERY, 8'hff, 16'sh7fff, -16'sh8000);
        set_path(1'b1, 9'd1);
        send_item(pcli_pkg::OP_QUERY, 8'h00, -16'sh8000, 16'sh7fff);
    endtask

    task automatic test_extremes;
        send_item(pcli_pkg::OP_WRITE, 8'd0, -16'sh8000, -16'sh8000);
        send_item(pcli_pkg::OP_WRITE, 8'd1, 16'sh7fff, 16'sh7fff);
        set_path(1'b0, 9'd2);
        send_item(pcli_pkg::OP_QUERY, 8'd0, -16'sh8000, 16'sh7fff);
        send_item(pcli_pkg::OP_QUERY, 8'd0, 16'sh7fff, -16'sh8000);
        send_item(pcli_pkg::OP_QUERY, 8'd0, -16'sh8000, -16'sh8000);
        send_item(pcli_pkg::OP_QUERY, 8'd0, 16'sh7fff, 16'sh7fff);
        send_item(pcli_pkg::OP_QUERY, 8'd0, 16'sh0000, 16'sh0001);
    endtask

    task automatic test_zero_length;
        send_item(pcli_pkg::OP_WRITE, 8'd1, -16'sh8000, -16'sh8000);
        send_item(pcli_pkg::OP_QUERY, 8'd0, 16'sh7fff, 16'sh7fff);
    endtask

    task automatic test_equal_distance;
        send_item(pcli_pkg::OP_WRITE, 8'd0, 16'sd0, 16'sd0);
        send_item(pcli_pkg::OP_WRITE, 8'd1, 16'sd10, 16'sd0);
        send_item(pcli_pkg::OP_WRITE, 8'd2, 16'sd20, 16'sd0);
        set_path(1'b0, 9'd3);
        send_item(pcli_pkg::OP_QUERY, 8'd0, 16'sd10, 16'sd5);
        set_path(1'b1, 9'd3);
        send_item(pcli_pkg::OP_QUERY, 8'd0, 16'sd10, -16'sd5);
        send_item(pcli_pkg::OP_QUERY, 8'd0, 16'sd0, 16'sd0);
    endtask

    task automatic fill_points(int n, int span);
        for (int i = 0; i < n; i++)
            send_item(pcli_pkg::OP_WRITE, i[7:0], shortint'($urandom_range(2 * span) - span),
                      shortint'($urandom_range(2 * span) - span));
    endtask

    task automatic random_target(int span);
        send_item(pcli_pkg::OP_QUERY, 8'($urandom),
                  shortint'($urandom_range(2 * span) - span),
                  shortint'($urandom_range(2 * span) - span));
    endtask

    task automatic test_saturated_count;
        fill_points(256, 32768);
        set_path(1'b1, 9'd511);
        random_target(32768);
        set_path(1'b0, 9'd256);
        random_target(32768);
        set_path(1'b1, 9'd300);
        random_target(32768);
    endtask

    task automatic test_backpressure;
        fill_points(4, 32768);
        set_path(1'b0, 9'd4);
        hold_reqs++;
        for (int i = 0; i < 20; i++)
            random_target(32768);
    endtask

    task automatic test_random;
        int n, span, count;
        while (items_sent < ITEM_GOAL)
        begin
            if ($urandom_range(99) < 4)
                count = $urandom_range(1) ? 256 : $urandom_range(257, 511);
            else
                count = $urandom_range(2, 12);
            n = count > 256 ? 256 : count;
            span = $urandom_range(2) == 0 ? 3 : ($urandom_range(1) ? 300 : 32768);
            steady = (phases % 7 == 3);
            fill_points(n, span);
            set_path(1'($urandom), 9'(count));
            for (int k = 0; k < 12; k++)
            begin
                if ($urandom_range(99) < 70)
                    random_target(span + 2);
                else
                    send_item(pcli_pkg::OP_WRITE, 8'($urandom), shortint'($urandom),
                              shortint'($urandom));
            end
        end
        steady = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (hold_reqs != hold_seen)
        begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 21);
    end

    always @(posedge clk)
    begin
        nearest_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (nearest_q.size() == 0)
            begin
                $display("%0t: unexpected result seg=%0d frac=%0d few=%0d", $time,
                         m_axis_tdata[7:0], m_axis_tdata[24:8], m_axis_tuser);
                errors++;
            end
            else
            begin
                want = nearest_q.pop_front();
                if (m_axis_tdata[7:0] !== want.seg)
                begin
                    $display("%0t: segment_index expected %0d actual %0d", $time,
                             want.seg, m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tdata[24:8] !== want.frac)
                begin
                    $display("%0t: fraction expected %0d actual %0d", $time,
                             want.frac, m_axis_tdata[24:8]);
                    errors++;
                end
                if (m_axis_tuser !== want.few)
                begin
                    $display("%0t: too_few_vertices expected %0d actual %0d", $time,
                             want.few, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, nearest_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        errors = 0; items_sent = 0; queries_sent = 0; results_seen = 0; phases = 0;
        cycles = 0; steady = 1'b0; hold_reqs = 0; hold_seen = 0; hold_left = 0;
        closed_mode = 1'b0;
        point_count = '0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_too_few();
        test_extremes();
        test_zero_length();
        test_equal_distance();
        test_saturated_count();
        test_backpressure();
        drain();
        test_random();
        drain();
        repeat (50) @(posedge clk);
        $display("Ran %0d items (%0d queries, %0d results) over %0d path settings,",
                 items_sent, queries_sent, results_seen, phases);
        $display("open and closed paths, short to saturated counts, stalls on both sides.");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
